// File: hw/rtl/vsma_pkg.sv
// ----------------------------------------------------------------------------
// vsma_pkg
// shared constants, codes and types of the mix bus accumulator
// ----------------------------------------------------------------------------
package vsma_pkg;

    // default geometry
    localparam int MAX_GROUPS_DEF        = 8;
    localparam int SAMPLES_PER_BLOCK_DEF = 64;
    localparam int BLOCKS_PER_RENDER_DEF = 16;

    // configuration register indexes
    localparam logic [1:0] REG_AUDIO_GROUPS   = 2'd0;
    localparam logic [1:0] REG_REVERB_SEND_ON = 2'd1;
    localparam logic [1:0] REG_CHORUS_SEND_ON = 2'd2;

    // configuration reset values
    localparam logic [3:0] AUDIO_GROUPS_RST   = 4'd1;
    localparam logic       REVERB_SEND_ON_RST = 1'b1;
    localparam logic       CHORUS_SEND_ON_RST = 1'b1;

    // item kinds
    localparam logic KIND_MIX  = 1'b0;
    localparam logic KIND_READ = 1'b1;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_SKIP  = 2'd2;

    // field widths
    localparam int SAMPLE_W  = 16;
    localparam int GAIN_W    = 18;
    localparam int PROD_W    = SAMPLE_W + GAIN_W;
    localparam int ACC_W     = 32;
    localparam int RND_SHIFT = 14;
    localparam int RND_W     = PROD_W + 1 - RND_SHIFT;

    // multiply-accumulate stage enables
    typedef struct packed {
        logic mul_en;
        logic rnd_en;
    } mac_ctrl_t;

endpackage

// File: hw/rtl/vsma_acc_mem.sv
// ----------------------------------------------------------------------------
// vsma_acc_mem
// accumulator store: one write port, one registered read port, clear sweep
// after reset
// ----------------------------------------------------------------------------
module vsma_acc_mem
    import vsma_pkg::*;
#(
    parameter int DEPTH  = 18432,
    parameter int ADDR_W = $clog2(DEPTH)
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    rd_en,
    input  logic [ADDR_W-1:0]       rd_addr,
    output logic signed [ACC_W-1:0] rd_data,
    input  logic                    wr_en,
    input  logic [ADDR_W-1:0]       wr_addr,
    input  logic signed [ACC_W-1:0] wr_data,
    output logic                    clearing
);

    logic signed [ACC_W-1:0] acc_mem [DEPTH];
    logic signed [ACC_W-1:0] rd_data_reg;
    logic [ADDR_W-1:0]       clr_cnt_reg;
    logic [ADDR_W-1:0]       clr_cnt_next;
    logic                    clearing_reg;
    logic                    clearing_next;
    logic                    we;
    logic [ADDR_W-1:0]       waddr;
    logic signed [ACC_W-1:0] wdata;

    always_comb
    begin
        clr_cnt_next  = clr_cnt_reg;
        clearing_next = clearing_reg;
        if (clearing_reg)
        begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == ADDR_W'(DEPTH - 1))
            begin
                clearing_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg  <= '0;
            clearing_reg <= 1'b1;
        end
        else
        begin
            clr_cnt_reg  <= clr_cnt_next;
            clearing_reg <= clearing_next;
        end
    end

    // the sweep owns the write port until every entry is zero
    assign we    = clearing_reg | wr_en;
    assign waddr = clearing_reg ? clr_cnt_reg : wr_addr;
    assign wdata = clearing_reg ? '0 : wr_data;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            acc_mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= acc_mem[rd_addr];
        end
    end

    assign rd_data  = rd_data_reg;
    assign clearing = clearing_reg;

endmodule

// File: hw/rtl/vsma_mac.sv
// ----------------------------------------------------------------------------
// vsma_mac
// registered multiply, registered round to Q17.15, saturating add
// ----------------------------------------------------------------------------
module vsma_mac
    import vsma_pkg::*;
(
    input  logic                       clk,
    input  mac_ctrl_t                  ctrl,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic signed [GAIN_W-1:0]   gain,
    input  logic signed [ACC_W-1:0]    acc,
    output logic signed [ACC_W-1:0]    sum_sat
);

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [RND_W-1:0]  rnd_reg;
    logic signed [PROD_W:0]   biased;
    logic signed [ACC_W:0]    sum;

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            prod_reg <= PROD_W'(sample) * PROD_W'(gain);
        end
    end

    // round half up: add half an lsb, then floor
    assign biased = {prod_reg[PROD_W-1], prod_reg} + (PROD_W+1)'(1 << (RND_SHIFT - 1));

    always_ff @(posedge clk)
    begin
        if (ctrl.rnd_en)
        begin
            rnd_reg <= biased[PROD_W:RND_SHIFT];
        end
    end

    assign sum = {acc[ACC_W-1], acc} + (ACC_W+1)'(rnd_reg);

    always_comb
    begin
        if (sum[ACC_W] != sum[ACC_W-1])
        begin
            sum_sat = sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end
        else
        begin
            sum_sat = sum[ACC_W-1:0];
        end
    end

endmodule

// File: hw/rtl/voice_send_mixdown_accumulator.sv
// ----------------------------------------------------------------------------
// voice_send_mixdown_accumulator
// mix bus accumulator: adds gain * sample into one bus entry per item, or
// reads and clears one entry
// ----------------------------------------------------------------------------
//  channel   ports                                              handshake
//  config    cfg_we cfg_addr cfg_wdata                          write on cfg_we
//  item      kind dest_index sample_index sample gain           start & !busy
//  result    read_value status                                  done, one cycle
//
//  an item runs from one transfer to the next through capture, then
//  decode with the store read and the multiply, then round, then add,
//  saturate and write back; done is high in the cycle after write back, and
//  the next item may be taken at the end of that cycle. items never overlap
//  on the read-modify-write of the store; a new item waits for the last one.
//  after reset busy stays high while all SLOT_COUNT*PERIOD_LEN entries (18432
//  at the defaults) of the store are swept to zero; config writes still land.
//  the receiver cannot stall: every result is marked by done for one cycle.
// ----------------------------------------------------------------------------
module voice_send_mixdown_accumulator
    import vsma_pkg::*;
#(
    parameter int MAX_GROUPS        = MAX_GROUPS_DEF,
    parameter int SAMPLES_PER_BLOCK = SAMPLES_PER_BLOCK_DEF,
    parameter int BLOCKS_PER_RENDER = BLOCKS_PER_RENDER_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [1:0]                 cfg_addr,
    input  logic [3:0]                 cfg_wdata,
    input  logic                       start,
    output logic                       busy,
    input  logic                       kind,
    input  logic [4:0]                 dest_index,
    input  logic [9:0]                 sample_index,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic signed [GAIN_W-1:0]   gain,
    output logic                       done,
    output logic signed [ACC_W-1:0]    read_value,
    output logic [1:0]                 status
);

    localparam int PERIOD_LEN  = SAMPLES_PER_BLOCK * BLOCKS_PER_RENDER;
    localparam int SLOT_COUNT  = 2 * MAX_GROUPS + 2;
    localparam int DEPTH       = SLOT_COUNT * PERIOD_LEN;
    localparam int ADDR_W      = $clog2(DEPTH);
    localparam int SLOT_W      = $clog2(SLOT_COUNT);
    localparam logic [SLOT_W-1:0] REVERB_SLOT = SLOT_W'(2 * MAX_GROUPS);
    localparam logic [SLOT_W-1:0] CHORUS_SLOT = SLOT_W'(2 * MAX_GROUPS + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DEC  = 2'd1;
    localparam logic [1:0] S_RND  = 2'd2;
    localparam logic [1:0] S_EXEC = 2'd3;

    logic [1:0]                 state_reg;
    logic [1:0]                 state_next;
    logic [3:0]                 groups_cfg_reg;
    logic                       reverb_on_reg;
    logic                       chorus_on_reg;

    logic                       kind_reg;
    logic [4:0]                 dest_reg;
    logic [9:0]                 pos_reg;
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic signed [GAIN_W-1:0]   gain_reg;

    logic [ADDR_W-1:0]          addr_reg;
    logic                       bad_reg;
    logic                       skip_reg;
    logic                       bad_next;
    logic                       skip_next;

    logic                       done_reg;
    logic signed [ACC_W-1:0]    value_reg;
    logic [1:0]                 status_reg;

    logic                       accept;
    logic                       clearing;
    logic [4:0]                 groups_eff;
    logic [5:0]                 dbl;
    logic [5:0]                 dest_ext;
    logic [SLOT_W-1:0]          slot;
    logic [ADDR_W-1:0]          addr_dec;
    logic                       is_reverb;
    logic                       is_chorus;

    logic                       mem_rd_en;
    logic signed [ACC_W-1:0]    mem_rd_data;
    logic                       mem_wr_en;
    logic signed [ACC_W-1:0]    mem_wr_data;
    mac_ctrl_t                  mac_ctrl;
    logic signed [ACC_W-1:0]    sum_sat;

    assign busy   = (state_reg != S_IDLE) | clearing;
    assign accept = start & ~busy;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            groups_cfg_reg <= AUDIO_GROUPS_RST;
            reverb_on_reg  <= REVERB_SEND_ON_RST;
            chorus_on_reg  <= CHORUS_SEND_ON_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_AUDIO_GROUPS:   groups_cfg_reg <= cfg_wdata;
                REG_REVERB_SEND_ON: reverb_on_reg  <= cfg_wdata[0];
                REG_CHORUS_SEND_ON: chorus_on_reg  <= cfg_wdata[0];
                default:            ;
            endcase
        end
    end

    // item capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg   <= kind;
            dest_reg   <= dest_index;
            pos_reg    <= sample_index;
            sample_reg <= sample;
            gain_reg   <= gain;
        end
    end

    // destination decode
    always_comb
    begin
        groups_eff = (5'(groups_cfg_reg) > 5'(MAX_GROUPS)) ? 5'(MAX_GROUPS)
                                                          : 5'(groups_cfg_reg);
        dbl        = {groups_eff, 1'b0};
        dest_ext   = {1'b0, dest_reg};
        is_reverb  = (dest_ext == dbl);
        is_chorus  = (dest_ext == dbl + 6'd1);
        bad_next   = (dest_ext >= dbl + 6'd2) || (32'(pos_reg) >= PERIOD_LEN);
        if (dest_ext < dbl)
        begin
            slot = SLOT_W'(dest_reg);
        end
        else if (is_reverb)
        begin
            slot = REVERB_SLOT;
        end
        else
        begin
            slot = CHORUS_SLOT;
        end
        addr_dec  = ADDR_W'(32'(slot) * 32'(PERIOD_LEN) + 32'(pos_reg));
        skip_next = (gain_reg == '0) || (is_reverb && !reverb_on_reg)
                    || (is_chorus && !chorus_on_reg);
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_DEC)
        begin
            addr_reg <= addr_dec;
            bad_reg  <= bad_next;
            skip_reg <= skip_next;
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (accept) state_next = S_DEC;
            S_DEC:   state_next = S_RND;
            S_RND:   state_next = S_EXEC;
            S_EXEC:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == S_EXEC);
        end
    end

    assign mem_rd_en       = (state_reg == S_DEC);
    assign mac_ctrl.mul_en = (state_reg == S_DEC);
    assign mac_ctrl.rnd_en = (state_reg == S_RND);

    // a read clears the entry, a live mix writes the saturated sum
    assign mem_wr_en   = (state_reg == S_EXEC) && !bad_reg
                         && ((kind_reg == KIND_READ) || !skip_reg);
    assign mem_wr_data = (kind_reg == KIND_READ) ? '0 : sum_sat;

    always_ff @(posedge clk)
    begin
        if (state_reg == S_EXEC)
        begin
            value_reg <= (!bad_reg && kind_reg == KIND_READ) ? mem_rd_data : '0;
            if (bad_reg)
            begin
                status_reg <= ST_RANGE;
            end
            else if (kind_reg == KIND_MIX && skip_reg)
            begin
                status_reg <= ST_SKIP;
            end
            else
            begin
                status_reg <= ST_OK;
            end
        end
    end

    assign done       = done_reg;
    assign read_value = value_reg;
    assign status     = status_reg;

    vsma_acc_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (mem_rd_en),
        .rd_addr  (addr_dec),
        .rd_data  (mem_rd_data),
        .wr_en    (mem_wr_en),
        .wr_addr  (addr_reg),
        .wr_data  (mem_wr_data),
        .clearing (clearing)
    );

    vsma_mac u_mac (
        .clk     (clk),
        .ctrl    (mac_ctrl),
        .sample  (sample_reg),
        .gain    (gain_reg),
        .acc     (mem_rd_data),
        .sum_sat (sum_sat)
    );

`ifndef SYNTHESIS
    a_done_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == S_EXEC))
        else $error("result strobe without a finished item");

    a_no_item_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> (busy && state_reg == S_IDLE))
        else $error("item in flight during store clear");

    a_write_only_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
        mem_wr_en |-> (state_reg == S_EXEC && !clearing))
        else $error("store write outside the write-back cycle");

    a_nonok_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != ST_OK) |-> (read_value == '0))
        else $error("nonzero value on a flagged or skipped result");
`endif

endmodule

// File: tb/sv/voice_send_mixdown_accumulator_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voice_send_mixdown_accumulator_test
// self-checking bench for the mix bus accumulator: directed mixes, reads and
// send/group settings, a full-scale run, then random traffic over several
// settings, every result checked against an in-bench model of the bus store
// ----------------------------------------------------------------------------
module voice_send_mixdown_accumulator_test;
    import vsma_pkg::*;

    localparam int PERIOD_LEN     = SAMPLES_PER_BLOCK_DEF * BLOCKS_PER_RENDER_DEF;
    localparam int SLOT_COUNT     = 2 * MAX_GROUPS_DEF + 2;
    localparam int STORE_DEPTH    = SLOT_COUNT * PERIOD_LEN;
    localparam int DRAIN_CYCLES   = 6;
    localparam int WATCHDOG_LIMIT = 100000;

    localparam logic [1:0] REG_UNUSED = 2'd3;

    localparam logic signed [15:0] SAMPLE_MAX = 16'sh7fff;
    localparam logic signed [15:0] SAMPLE_MIN = 16'sh8000;
    localparam logic signed [17:0] GAIN_MAX   = 18'sh1ffff;
    localparam logic signed [17:0] GAIN_MIN   = 18'sh20000;

    typedef struct {
        logic               kind;
        logic [4:0]         dest;
        logic [9:0]         pos;
        logic signed [15:0] smp;
        logic signed [17:0] gn;
    } bus_item_t;

    typedef struct {
        logic signed [31:0] value;
        logic [1:0]         st;
    } bus_result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [1:0]         cfg_addr = '0;
    logic [3:0]         cfg_wdata = '0;
    logic               start = 1'b0;
    logic               busy;
    logic               kind = KIND_MIX;
    logic [4:0]         dest_index = '0;
    logic [9:0]         sample_index = '0;
    logic signed [15:0] sample = '0;
    logic signed [17:0] gain = '0;
    logic               done;
    logic signed [31:0] read_value;
    logic [1:0]         status;

    // model of the bus store and its settings
    logic signed [31:0] bus_store [0:STORE_DEPTH-1];
    logic [3:0]         bus_groups = AUDIO_GROUPS_RST;
    logic               reverb_on = REVERB_SEND_ON_RST;
    logic               chorus_on = CHORUS_SEND_ON_RST;

    bus_result_t pending_results[$];
    int          mismatch_count = 0;
    int          stall_cycles = 0;

    voice_send_mixdown_accumulator dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .start        (start),
        .busy         (busy),
        .kind         (kind),
        .dest_index   (dest_index),
        .sample_index (sample_index),
        .sample       (sample),
        .gain         (gain),
        .done         (done),
        .read_value   (read_value),
        .status       (status)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic int unsigned active_groups();
        return (bus_groups > MAX_GROUPS_DEF) ? MAX_GROUPS_DEF : int'(bus_groups);
    endfunction

    function automatic bus_item_t make_item(input logic k, input int d, input int p,
                                            input int s, input int g);
        bus_item_t it;
        it.kind = k;
        it.dest = 5'(d);
        it.pos  = 10'(p);
        it.smp  = 16'(s);
        it.gn   = 18'(g);
        return it;
    endfunction

    // mix or read-and-clear against the model store
    function automatic bus_result_t predict_mix_result(input bus_item_t it);
        bus_result_t  res;
        int unsigned  groups;
        int unsigned  slot;
        int unsigned  idx;
        bit           to_reverb;
        bit           to_chorus;
        longint       prod;
        longint       rounded;
        longint       total;
        groups    = active_groups();
        res.value = '0;
        res.st    = ST_OK;
        to_reverb = 1'b0;
        to_chorus = 1'b0;
        if (it.dest >= 2 * groups + 2 || it.pos >= PERIOD_LEN)
        begin
            res.st = ST_RANGE;
            return res;
        end
        if (it.dest < 2 * groups)
            slot = it.dest;
        else if (it.dest == 2 * groups)
        begin
            slot      = 2 * MAX_GROUPS_DEF;
            to_reverb = 1'b1;
        end
        else
        begin
            slot      = 2 * MAX_GROUPS_DEF + 1;
            to_chorus = 1'b1;
        end
        idx = slot * PERIOD_LEN + it.pos;
        if (it.kind == KIND_READ)
        begin
            res.value      = bus_store[idx];
            bus_store[idx] = '0;
            return res;
        end
        if (it.gn == 0 || (to_reverb && !reverb_on) || (to_chorus && !chorus_on))
        begin
            res.st = ST_SKIP;
            return res;
        end
        // Q4.29 product to Q17.15, round half up
        prod    = longint'(it.smp) * longint'(it.gn);
        rounded = (prod + 64'sd8192) >>> 14;
        total   = longint'(bus_store[idx]) + rounded;
        if (total > 64'sd2147483647)
            total = 64'sd2147483647;
        if (total < -64'sd2147483648)
            total = -64'sd2147483648;
        bus_store[idx] = 32'(total);
        return res;
    endfunction

    function automatic bus_item_t random_item();
        bus_item_t   it;
        int unsigned span;
        int unsigned r;
        span    = 2 * active_groups() + 2;
        it.kind = ($urandom_range(0, 4) == 0) ? KIND_READ : KIND_MIX;
        it.dest = ($urandom_range(0, 9) < 8) ? 5'($urandom_range(0, span - 1))
                                              : 5'($urandom_range(0, 31));
        // a few hot positions so entries build up between reads
        if ($urandom_range(0, 9) < 7)
            it.pos = $urandom_range(0, 1) ? 10'($urandom_range(0, 3))
                                          : 10'($urandom_range(1020, 1023));
        else
            it.pos = 10'($urandom);
        r = $urandom_range(0, 19);
        it.smp = (r == 0) ? SAMPLE_MIN : (r == 1) ? SAMPLE_MAX : 16'($urandom);
        r = $urandom_range(0, 19);
        if (r < 2)
            it.gn = '0;
        else if (r == 2)
            it.gn = GAIN_MIN;
        else if (r == 3)
            it.gn = GAIN_MAX;
        else if (r == 4)
            it.gn = 18'($urandom_range(1, 3));
        else
            it.gn = 18'($urandom);
        return it;
    endfunction

    // start stays high after a transfer, so a following item with no gap
    // sees only one assignment to it in that step
    task automatic send_item(input bus_item_t it, input bit back_to_back);
        int unsigned gap;
        gap = back_to_back ? 0 : $urandom_range(0, 13);
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start        <= 1'b1;
        kind         <= it.kind;
        dest_index   <= it.dest;
        sample_index <= it.pos;
        sample       <= it.smp;
        gain         <= it.gn;
        do
            @(posedge clk);
        while (busy);
        pending_results.push_back(predict_mix_result(it));
    endtask

    task automatic drain();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] addr, input int data);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= 4'(data);
        @(posedge clk);
        case (addr)
            REG_AUDIO_GROUPS:   bus_groups = 4'(data);
            REG_REVERB_SEND_ON: reverb_on = 1'(data);
            REG_CHORUS_SEND_ON: chorus_on = 1'(data);
            default: ;
        endcase
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // reset settings: one group, so 0/1 are the group buses, 2 reverb, 3 chorus
    task automatic test_mix_basics();
        send_item(make_item(KIND_MIX, 0, 0, SAMPLE_MAX, GAIN_MAX), 1'b0);
        send_item(make_item(KIND_MIX, 0, 0, SAMPLE_MIN, GAIN_MIN), 1'b0);
        send_item(make_item(KIND_READ, 0, 0, SAMPLE_MAX, GAIN_MAX), 1'b0);
        send_item(make_item(KIND_READ, 0, 0, 0, 0), 1'b0);
        send_item(make_item(KIND_MIX, 1, 1023, SAMPLE_MIN, GAIN_MAX), 1'b0);
        send_item(make_item(KIND_READ, 1, 1023, 0, 0), 1'b0);
        // zero gain, rounding to zero, and the half-up case both ways
        send_item(make_item(KIND_MIX, 0, 5, 1234, 0), 1'b0);
        send_item(make_item(KIND_MIX, 0, 5, 1, 1), 1'b0);
        send_item(make_item(KIND_MIX, 0, 5, 1, 8192), 1'b0);
        send_item(make_item(KIND_MIX, 0, 5, -1, 8192), 1'b0);
        send_item(make_item(KIND_READ, 0, 5, 0, 0), 1'b0);
        send_item(make_item(KIND_MIX, 4, 0, 100, 100), 1'b0);
        send_item(make_item(KIND_READ, 31, 1023, 0, 0), 1'b0);
        send_item(make_item(KIND_MIX, 2, 7, -20000, 90000), 1'b0);
        send_item(make_item(KIND_MIX, 3, 7, 30000, -70000), 1'b0);
        send_item(make_item(KIND_READ, 3, 7, 0, 0), 1'b0);
    endtask

    task automatic test_send_settings();
        drain();
        write_reg(REG_REVERB_SEND_ON, 0);
        write_reg(REG_CHORUS_SEND_ON, 0);
        send_item(make_item(KIND_MIX, 2, 7, 500, 500), 1'b0);
        send_item(make_item(KIND_MIX, 3, 7, 500, 500), 1'b0);
        // reads of a disabled send still work
        send_item(make_item(KIND_READ, 2, 7, 0, 0), 1'b0);
        drain();
        // no groups: 0 is reverb, 1 is chorus
        write_reg(REG_AUDIO_GROUPS, 0);
        write_reg(REG_REVERB_SEND_ON, 1);
        send_item(make_item(KIND_MIX, 0, 9, 4000, 4000), 1'b0);
        send_item(make_item(KIND_MIX, 1, 9, 4000, 4000), 1'b0);
        send_item(make_item(KIND_READ, 2, 9, 0, 0), 1'b0);
        drain();
        // above the maximum acts as the maximum
        write_reg(REG_AUDIO_GROUPS, 15);
        write_reg(REG_UNUSED, 3);
        write_reg(REG_CHORUS_SEND_ON, 1);
        send_item(make_item(KIND_MIX, 17, 9, -4000, 4000), 1'b0);
        send_item(make_item(KIND_READ, 16, 9, 0, 0), 1'b0);
        send_item(make_item(KIND_MIX, 18, 9, 4000, 4000), 1'b0);
        send_item(make_item(KIND_READ, 17, 9, 0, 0), 1'b0);
        drain();
        write_reg(REG_AUDIO_GROUPS, MAX_GROUPS_DEF);
        send_item(make_item(KIND_MIX, 15, 9, SAMPLE_MAX, GAIN_MIN), 1'b0);
        send_item(make_item(KIND_READ, 15, 9, 0, 0), 1'b0);
    endtask

    // back-to-back full-scale adds push two entries far out both ways
    task automatic test_full_scale();
        send_item(make_item(KIND_READ, 0, 100, 0, 0), 1'b0);
        send_item(make_item(KIND_READ, 1, 100, 0, 0), 1'b0);
        for (int n = 0; n < 20; n++)
        begin
            send_item(make_item(KIND_MIX, 0, 100, SAMPLE_MIN, GAIN_MIN), 1'b1);
            send_item(make_item(KIND_MIX, 1, 100, SAMPLE_MIN, GAIN_MAX), 1'b1);
        end
        send_item(make_item(KIND_MIX, 0, 100, SAMPLE_MIN, GAIN_MAX), 1'b0);
        send_item(make_item(KIND_READ, 0, 100, 0, 0), 1'b0);
        send_item(make_item(KIND_READ, 1, 100, 0, 0), 1'b0);
    endtask

    task automatic test_random_traffic();
        bit burst;
        for (int phase = 0; phase < 4; phase++)
        begin
            drain();
            case (phase)
                0:       write_reg(REG_AUDIO_GROUPS, MAX_GROUPS_DEF);
                1:       write_reg(REG_AUDIO_GROUPS, 0);
                2:       write_reg(REG_AUDIO_GROUPS, 15);
                default: write_reg(REG_AUDIO_GROUPS, $urandom_range(1, 7));
            endcase
            write_reg(REG_REVERB_SEND_ON, $urandom_range(0, 1));
            write_reg(REG_CHORUS_SEND_ON, $urandom_range(0, 1));
            burst = 1'b0;
            for (int n = 0; n < 230; n++)
            begin
                if (n % 50 == 0)
                    burst = ($urandom_range(0, 2) == 0);
                // hold off until the pipe is empty now and then
                if ($urandom_range(0, 39) == 0)
                    drain();
                send_item(random_item(), burst);
            end
        end
    endtask

    always @(posedge clk)
    begin : result_check
        bus_result_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result transfer with nothing expected: read_value %0d status %0d",
                       read_value, status);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (read_value !== want.value)
                begin
                    $error("read_value: expected %0d, got %0d", want.value, read_value);
                    mismatch_count++;
                end
                if (status !== want.st)
                begin
                    $error("status: expected %0d, got %0d", want.st, status);
                    mismatch_count++;
                end
            end
        end
    end

    // covers the store sweep after reset as well
    always @(posedge clk)
    begin
        if ((rst_n && start && !busy) || done)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("voice_send_mixdown_accumulator_test: errors");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i < STORE_DEPTH; i++)
            bus_store[i] = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_mix_basics();
        test_send_settings();
        test_full_scale();
        test_random_traffic();
        drain();
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("voice_send_mixdown_accumulator_test: clean");
        else
            $display("voice_send_mixdown_accumulator_test: errors");
        $finish;
    end

endmodule
